// ----- sv/nvfcm_pkg.sv -----
// ----------------------------------------------------------------------------
// nvfcm_pkg
// Shared constants, codes and stage payload types for the noise value
// false-color map pipeline.
// ----------------------------------------------------------------------------
package nvfcm_pkg;

    localparam int NOISE_FRAC_BITS = 15;

    // sample and offset widths: range -2^F..2^F needs F+2 bits
    localparam int NV_W    = NOISE_FRAC_BITS + 2;
    localparam int TDATA_W = ((NV_W + 7) / 8) * 8;
    localparam int OFF_W   = NOISE_FRAC_BITS + 2;
    localparam int MAG_W   = NOISE_FRAC_BITS + 1;

    // hue in units of 1/2^(F+1) degree
    localparam int     HUE_SCALE = 360;
    localparam longint HQ_MAX    = longint'(HUE_SCALE) << (NOISE_FRAC_BITS + 1);
    localparam int     HQ_W      = $clog2(HQ_MAX + 1);
    localparam longint SEG       = longint'(240) << NOISE_FRAC_BITS;
    localparam int     D_W       = $clog2(SEG + 1);

    // 255 / (240 * 2^F) == 17 / 2^(F+4)
    localparam int RAMP_MUL = 17;
    localparam int RAMP_SH  = NOISE_FRAC_BITS + 4;
    localparam int RAMP_PW  = D_W + 5;

    localparam int COLOR_W  = 8;
    localparam int GRAY_MUL = 255;
    localparam int GRAY_SH  = NOISE_FRAC_BITS + 1;
    localparam int GRAY_PW  = OFF_W + COLOR_W;
    localparam logic [COLOR_W-1:0] COLOR_MAX = COLOR_W'(255);

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_GRAY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RGB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CYM  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIX  = 3'd4;

    typedef enum logic [1:0] {
        KIND_GRAY,
        KIND_BW,
        KIND_RGB,
        KIND_CYM
    } t_kind;

    typedef enum logic [1:0] {
        PART_LO,
        PART_MID,
        PART_HI
    } t_part;

    typedef struct packed {
        t_kind            kind;
        logic             neg;
        logic [OFF_W-1:0] hue_in;
    } t_s1;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [COLOR_W-1:0] gray;
        logic [HQ_W-1:0]    hq;
    } t_s2;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [COLOR_W-1:0] gray;
        t_part              part;
        logic [D_W-1:0]     seg_pos;
    } t_s3;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

endpackage

// ----- sv/nvfcm_prep.sv -----
// ----------------------------------------------------------------------------
// nvfcm_prep
// Stage 1: saturates the sample, picks the map kind and the hue operand.
// ----------------------------------------------------------------------------
module nvfcm_prep
    import nvfcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NV_W-1:0]   i_sample,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_valid,
    input  logic              i_ready,
    output t_s1               o_stage
);

    localparam logic signed [NV_W-1:0] ONE_P = NV_W'(longint'(1) << NOISE_FRAC_BITS);
    localparam logic signed [NV_W-1:0] ONE_N = -ONE_P;

    logic                   r_valid;
    t_s1                    r_stage;
    t_s1                    n_stage;
    logic signed [NV_W-1:0] w_v;
    logic signed [NV_W-1:0] w_sat;
    logic signed [NV_W-1:0] w_abs;
    logic [OFF_W-1:0]       w_off;
    logic [MAG_W-1:0]       w_mag;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    always_comb begin
        w_v = i_sample;
        if (w_v < ONE_N) begin
            w_sat = ONE_N;
        end else if (w_v > ONE_P) begin
            w_sat = ONE_P;
        end else begin
            w_sat = w_v;
        end
        w_off = OFF_W'(w_sat + ONE_P);
        w_abs = w_sat[NV_W-1] ? -w_sat : w_sat;
        w_mag = w_abs[MAG_W-1:0];

        n_stage.neg    = w_sat[NV_W-1];
        n_stage.hue_in = w_off;
        case (i_mode)
            MODE_BW:  n_stage.kind = KIND_BW;
            MODE_RGB: n_stage.kind = KIND_RGB;
            MODE_CYM: n_stage.kind = KIND_CYM;
            MODE_MIX: begin
                // 720*|v| == 360*(2*|v|)
                n_stage.kind   = w_sat[NV_W-1] ? KIND_CYM : KIND_RGB;
                n_stage.hue_in = {w_mag, 1'b0};
            end
            default:  n_stage.kind = KIND_GRAY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_stage <= n_stage;
        end
    end

endmodule

// ----- sv/nvfcm_scale.sv -----
// ----------------------------------------------------------------------------
// nvfcm_scale
// Stage 2: scales the operand to a hue and forms the gray level.
// ----------------------------------------------------------------------------
module nvfcm_scale
    import nvfcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_stage,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_stage
);

    logic               r_valid;
    t_s2                r_stage;
    t_s2                n_stage;
    logic [GRAY_PW-1:0] w_gray_p;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    always_comb begin
        w_gray_p     = GRAY_PW'(i_stage.hue_in) * GRAY_PW'(GRAY_MUL);
        n_stage.kind = i_stage.kind;
        n_stage.neg  = i_stage.neg;
        n_stage.gray = COLOR_W'(w_gray_p >> GRAY_SH);
        n_stage.hq   = HQ_W'(HQ_W'(i_stage.hue_in) * HQ_W'(HUE_SCALE));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_stage <= n_stage;
        end
    end

endmodule

// ----- sv/nvfcm_seg.sv -----
// ----------------------------------------------------------------------------
// nvfcm_seg
// Stage 3: finds the 120-degree segment and the distance into it.
// ----------------------------------------------------------------------------
module nvfcm_seg
    import nvfcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s2  i_stage,
    output logic o_valid,
    input  logic i_ready,
    output t_s3  o_stage
);

    localparam logic [HQ_W-1:0] SEG1 = HQ_W'(SEG);
    localparam logic [HQ_W-1:0] SEG2 = HQ_W'(2 * SEG);

    logic            r_valid;
    t_s3             r_stage;
    t_s3             n_stage;
    logic [HQ_W-1:0] w_start;
    logic [HQ_W-1:0] w_dist;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    always_comb begin
        n_stage.kind = i_stage.kind;
        n_stage.neg  = i_stage.neg;
        n_stage.gray = i_stage.gray;
        if (i_stage.hq < SEG1) begin
            n_stage.part = PART_LO;
            w_start      = '0;
        end else if (i_stage.hq < SEG2) begin
            n_stage.part = PART_MID;
            w_start      = SEG1;
        end else begin
            // top segment includes exactly 360 degrees (distance == SEG)
            n_stage.part = PART_HI;
            w_start      = SEG2;
        end
        w_dist          = i_stage.hq - w_start;
        n_stage.seg_pos = w_dist[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_stage <= n_stage;
        end
    end

endmodule

// ----- sv/nvfcm_ramp.sv -----
// ----------------------------------------------------------------------------
// nvfcm_ramp
// Stage 4: evaluates the rising and falling ramps and holds the output pixel.
// ----------------------------------------------------------------------------
module nvfcm_ramp
    import nvfcm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_s3    i_stage,
    output logic   o_valid,
    input  logic   i_ready,
    output t_pixel o_pixel
);

    localparam logic [D_W-1:0] SEG_D = D_W'(SEG);

    logic               r_valid;
    t_pixel             r_pixel;
    t_pixel             n_pixel;
    logic [RAMP_PW-1:0] w_up_p;
    logic [RAMP_PW-1:0] w_dn_p;
    logic [COLOR_W-1:0] w_up;
    logic [COLOR_W-1:0] w_dn;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

    always_comb begin
        w_up_p = RAMP_PW'(i_stage.seg_pos) * RAMP_PW'(RAMP_MUL);
        w_dn_p = RAMP_PW'(SEG_D - i_stage.seg_pos) * RAMP_PW'(RAMP_MUL);
        w_up   = COLOR_W'(w_up_p >> RAMP_SH);
        w_dn   = COLOR_W'(w_dn_p >> RAMP_SH);
        n_pixel = '0;
        case (i_stage.kind)
            KIND_BW: begin
                n_pixel.red   = i_stage.neg ? '0 : COLOR_MAX;
                n_pixel.green = n_pixel.red;
                n_pixel.blue  = n_pixel.red;
            end
            KIND_RGB: begin
                case (i_stage.part)
                    PART_LO: begin
                        n_pixel.red  = w_up;
                        n_pixel.blue = w_dn;
                    end
                    PART_MID: begin
                        n_pixel.green = w_up;
                        n_pixel.red   = w_dn;
                    end
                    default: begin
                        n_pixel.blue  = w_up;
                        n_pixel.green = w_dn;
                    end
                endcase
            end
            KIND_CYM: begin
                case (i_stage.part)
                    PART_LO: begin
                        n_pixel.red   = w_dn;
                        n_pixel.green = w_up;
                        n_pixel.blue  = w_up;
                    end
                    PART_MID: begin
                        n_pixel.red   = w_up;
                        n_pixel.green = w_up;
                        n_pixel.blue  = w_dn;
                    end
                    default: begin
                        n_pixel.red   = w_up;
                        n_pixel.green = w_dn;
                        n_pixel.blue  = w_up;
                    end
                endcase
            end
            default: begin
                n_pixel.red   = i_stage.gray;
                n_pixel.green = i_stage.gray;
                n_pixel.blue  = i_stage.gray;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pixel <= n_pixel;
        end
    end

endmodule

// ----- sv/noise_value_false_color_map_top.sv -----
// Each accepted input transaction passes four register stages (saturate, scale,
// segment, ramp); throughput is one pixel per cycle unless m_axis stalls.
// Each stage has its own valid bit and ready, so bubbles collapse.
// Reset (i_rst_n low, synchronous): all stage valid bits clear, color_mode
// returns to gray (0).
// ----------------------------------------------------------------------------
// noise_value_false_color_map_top
// Maps a signed Q15 noise sample to an RGB pixel under a configured mode.
// ----------------------------------------------------------------------------
module noise_value_false_color_map_top
    import nvfcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MODE_W-1:0]    i_cfg_data,      // color_mode
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,    // noise_value, zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [3*COLOR_W-1:0] m_axis_tdata     // red, green, blue
);

    logic [MODE_W-1:0] r_color_mode;
    logic   w_s1_valid;
    logic   w_s1_ready;
    t_s1    w_s1;
    logic   w_s2_valid;
    logic   w_s2_ready;
    t_s2    w_s2;
    logic   w_s3_valid;
    logic   w_s3_ready;
    t_s3    w_s3;
    t_pixel w_pixel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= MODE_GRAY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_color_mode <= i_cfg_data;
        end
    end

    nvfcm_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata[NV_W-1:0]),
        .i_mode   (r_color_mode),
        .o_valid  (w_s1_valid),
        .i_ready  (w_s1_ready),
        .o_stage  (w_s1)
    );

    nvfcm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_stage (w_s1),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_stage (w_s2)
    );

    nvfcm_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_stage (w_s2),
        .o_valid (w_s3_valid),
        .i_ready (w_s3_ready),
        .o_stage (w_s3)
    );

    nvfcm_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s3_valid),
        .o_ready (w_s3_ready),
        .i_stage (w_s3),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pixel (w_pixel)
    );

    assign m_axis_tdata = w_pixel;

    // input side only backs up when every stage holds an item and the sink stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!(w_s1_valid && w_s2_valid && w_s3_valid && m_axis_tvalid)
                          || m_axis_tready))
        else $error("input ready does not match pipeline occupancy");

    // an accepted input transaction always lands in stage 1
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_s1_valid)
        else $error("accepted transaction lost at stage 1");

    // a blocked stage holds its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_valid && !w_s1_ready) |=> (w_s1_valid && $stable(w_s1)))
        else $error("stage 1 item changed while stalled");

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s3_valid && !w_s3_ready) |=> (w_s3_valid && $stable(w_s3)))
        else $error("stage 3 item changed while stalled");

endmodule
